/* sv/quad_x_mixer_desaturate_top_defines.svh */
// Assertion macros used by the quad-X mixer top level.
`ifndef QUAD_X_MIXER_DESATURATE_TOP_DEFINES_SVH
`define QUAD_X_MIXER_DESATURATE_TOP_DEFINES_SVH
`ifndef SYNTH
`define QXMD_ASSERT(name, clk_s, rst_s, prop) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("quad-X mixer check failed");
`define QXMD_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("quad-X mixer check failed");
`else
`define QXMD_ASSERT(name, clk_s, rst_s, prop)
`define QXMD_ASSERT_IMP(name, clk_s, rst_s, ante, cons)
`endif
`endif

/* sv/qxmd_pkg.sv */
// Package of the quad-X mixer: widths, constants and pipeline word types.
package qxmd_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int DUTY_W     = 16;
  localparam int CORR_W     = 24;
  localparam int NUM_MOTORS = 4;

  localparam int M_BR = 0;
  localparam int M_FR = 1;
  localparam int M_FL = 2;
  localparam int M_BL = 3;

  localparam int DMAG_W = CORR_W + 1;
  localparam int D_W    = DMAG_W + 1;
  localparam int SPAN_W = D_W;
  localparam int LIM_W  = DUTY_W + FRAC_BITS;
  localparam int PROD_W = DMAG_W + LIM_W;
  localparam int QUO_W  = DMAG_W;
  localparam int CMP_W  = (PROD_W > SPAN_W + QUO_W) ? PROD_W : SPAN_W + QUO_W;
  localparam int M_W    = ((LIM_W + 1 > D_W) ? LIM_W + 1 : D_W) + 1;
  localparam int V_W    = M_W + 2;
  localparam int SUM_W  = DUTY_W + 3;
  localparam int SD_W   = SUM_W + FRAC_BITS - 2;
  localparam int FD_W   = ((CORR_W > SD_W) ? CORR_W : SD_W) + 1;
  localparam int ONE_Q  = 1 << FRAC_BITS;

  localparam int MIX_STAGES = 3;
  localparam int OUT_STAGES = 6;
  localparam int PIPE_DEPTH = MIX_STAGES + QUO_W + OUT_STAGES;

  localparam logic [DUTY_W-1:0] MAX_DUTY_RST = DUTY_W'(1023);

  typedef struct packed {
    logic [DUTY_W-1:0]        base_duty;
    logic signed [CORR_W-1:0] roll_cmd;
    logic signed [CORR_W-1:0] pitch_cmd;
    logic signed [CORR_W-1:0] yaw_cmd;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] motor_back_right;
    logic [DUTY_W-1:0] motor_front_right;
    logic [DUTY_W-1:0] motor_front_left;
    logic [DUTY_W-1:0] motor_back_left;
    logic              roll_short_pos;
    logic              roll_short_neg;
    logic              pitch_short_pos;
    logic              pitch_short_neg;
    logic              yaw_short_pos;
    logic              yaw_short_neg;
    logic              any_saturated;
    logic [DUTY_W-1:0] headroom;
  } out_word_t;

  typedef logic signed [D_W-1:0] dval_t;

  typedef struct packed {
    logic [LIM_W-1:0]              thr;
    logic signed [CORR_W-1:0]      roll;
    logic signed [CORR_W-1:0]      pitch;
    logic signed [CORR_W-1:0]      yaw;
    dval_t [NUM_MOTORS-1:0]        d;
  } side_t;

  typedef struct packed {
    logic [SPAN_W-1:0]                  span;
    logic                               scale;
    logic [NUM_MOTORS-1:0]              neg;
    logic [NUM_MOTORS-1:0][PROD_W-1:0]  rem;
    logic [NUM_MOTORS-1:0][QUO_W-1:0]   quo;
  } div_word_t;

endpackage

/* sv/qxmd_mix.sv */
// Front stages of the quad-X mixer: mix, extremes, scale products and span.
module qxmd_mix (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  qxmd_pkg::in_word_t          in_data,
  input  logic [qxmd_pkg::DUTY_W-1:0] max_duty,
  output logic                        out_valid,
  output qxmd_pkg::side_t             out_side,
  output qxmd_pkg::div_word_t         out_div
);
  import qxmd_pkg::*;

  logic [LIM_W-1:0]      lim;
  dval_t                 r_x, p_x, y_x;
  side_t                 s1_nxt, s1_side_r, s2_side_r, s3_side_r;
  logic                  s1_vld_r, s2_vld_r, s3_vld_r;
  dval_t                 dv [NUM_MOTORS];
  dval_t                 hi01, hi23, lo01, lo23, max_nxt, min_nxt;
  dval_t                 s2_max_r, s2_min_r;
  logic [DMAG_W-1:0]     mag [NUM_MOTORS];
  logic [PROD_W-1:0]     prod_nxt [NUM_MOTORS];
  logic [PROD_W-1:0]     s2_prod_r [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] neg_nxt, s2_neg_r;
  logic [SPAN_W-1:0]     span_nxt;
  logic                  scale_nxt;
  div_word_t             s3_nxt, s3_div_r;

  assign lim = {max_duty, {FRAC_BITS{1'b0}}};
  assign r_x = {{(D_W-CORR_W){in_data.roll_cmd[CORR_W-1]}}, in_data.roll_cmd};
  assign p_x = {{(D_W-CORR_W){in_data.pitch_cmd[CORR_W-1]}},
                in_data.pitch_cmd};
  assign y_x = {{(D_W-CORR_W){in_data.yaw_cmd[CORR_W-1]}}, in_data.yaw_cmd};

  // Offsets of each motor from the throttle.
  always_comb begin
    s1_nxt.thr     = {in_data.base_duty, {FRAC_BITS{1'b0}}};
    s1_nxt.roll    = in_data.roll_cmd;
    s1_nxt.pitch   = in_data.pitch_cmd;
    s1_nxt.yaw     = in_data.yaw_cmd;
    s1_nxt.d[M_BR] = r_x - p_x - y_x;
    s1_nxt.d[M_FR] = r_x + p_x + y_x;
    s1_nxt.d[M_FL] = p_x - r_x - y_x;
    s1_nxt.d[M_BL] = y_x - p_x - r_x;
  end

  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      dv[i]       = s1_side_r.d[i];
      neg_nxt[i]  = dv[i][D_W-1];
      mag[i]      = neg_nxt[i] ? DMAG_W'(-dv[i]) : DMAG_W'(dv[i]);
      prod_nxt[i] = PROD_W'(mag[i]) * PROD_W'(lim);
    end
    hi01    = (dv[0] > dv[1]) ? dv[0] : dv[1];
    hi23    = (dv[2] > dv[3]) ? dv[2] : dv[3];
    lo01    = (dv[0] < dv[1]) ? dv[0] : dv[1];
    lo23    = (dv[2] < dv[3]) ? dv[2] : dv[3];
    max_nxt = (hi01 > hi23) ? hi01 : hi23;
    min_nxt = (lo01 < lo23) ? lo01 : lo23;
  end

  always_comb begin
    span_nxt  = SPAN_W'(s2_max_r - s2_min_r);
    scale_nxt = {{LIM_W{1'b0}}, span_nxt} > {{SPAN_W{1'b0}}, lim};
    s3_nxt.span  = span_nxt;
    s3_nxt.scale = scale_nxt;
    s3_nxt.neg   = s2_neg_r;
    s3_nxt.quo   = '0;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      s3_nxt.rem[i] = s2_prod_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_side_r <= s1_nxt;
    s2_side_r <= s1_side_r;
    s2_max_r  <= max_nxt;
    s2_min_r  <= min_nxt;
    s2_prod_r <= prod_nxt;
    s2_neg_r  <= neg_nxt;
    s3_side_r <= s2_side_r;
    s3_div_r  <= s3_nxt;
  end

  assign out_valid = s3_vld_r;
  assign out_side  = s3_side_r;
  assign out_div   = s3_div_r;

endmodule

/* sv/qxmd_div.sv */
// Pipelined restoring divider of the quad-X mixer, one quotient bit per stage.
module qxmd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  qxmd_pkg::side_t     in_side,
  input  qxmd_pkg::div_word_t in_div,
  output logic                out_valid,
  output qxmd_pkg::side_t     out_side,
  output qxmd_pkg::div_word_t out_div
);
  import qxmd_pkg::*;

  logic [QUO_W-1:0] vld_r;
  side_t            side_r  [QUO_W];
  div_word_t        div_src [QUO_W];
  div_word_t        div_nxt [QUO_W];
  div_word_t        div_r   [QUO_W];

  always_comb begin
    div_src[0] = in_div;
    for (int s = 1; s < QUO_W; s++) begin
      div_src[s] = div_r[s-1];
    end
  end

  // Stage s tests the divisor shifted to quotient bit QUO_W-1-s.
  always_comb begin
    logic [CMP_W-1:0] sub_w;
    logic [CMP_W-1:0] rem_w;
    for (int s = 0; s < QUO_W; s++) begin
      div_nxt[s] = div_src[s];
      sub_w      = CMP_W'(div_src[s].span) << (QUO_W - 1 - s);
      for (int i = 0; i < NUM_MOTORS; i++) begin
        rem_w = CMP_W'(div_src[s].rem[i]);
        if (rem_w >= sub_w) begin
          div_nxt[s].rem[i] = PROD_W'(rem_w - sub_w);
          div_nxt[s].quo[i] = {div_src[s].quo[i][QUO_W-2:0], 1'b1};
        end else begin
          div_nxt[s].quo[i] = {div_src[s].quo[i][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QUO_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    div_r     <= div_nxt;
    side_r[0] <= in_side;
    for (int s = 1; s < QUO_W; s++) begin
      side_r[s] <= side_r[s-1];
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];
  assign out_div   = div_r[QUO_W-1];

endmodule

/* sv/qxmd_out.sv */
// Quad-X mixer back stages: select, extremes, shift, duty clamp, axis check, output.
module qxmd_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  qxmd_pkg::side_t             in_side,
  input  qxmd_pkg::div_word_t         in_div,
  input  logic [qxmd_pkg::DUTY_W-1:0] max_duty,
  output logic                        out_valid,
  output qxmd_pkg::out_word_t         out_data
);
  import qxmd_pkg::*;

  side_t                   o1_nxt, o1_side_r, o2_side_r, o3_side_r, o4_side_r, o5_side_r;
  logic                    o1_vld_r, o2_vld_r, o3_vld_r, o4_vld_r, o5_vld_r, out_valid_r;
  dval_t                   dsel [NUM_MOTORS];
  dval_t                   hi01, hi23, lo01, lo23, max_nxt, min_nxt;
  dval_t                   o2_max_r, o2_min_r;
  logic signed [M_W-1:0]   thr_s, lim_s, hi_s, lo_s;
  logic signed [M_W-1:0]   m_nxt [NUM_MOTORS];
  logic signed [M_W-1:0]   o3_m_r [NUM_MOTORS];
  logic signed [M_W:0]     shift_nxt, o3_shift_r;
  logic [DUTY_W-1:0]       duty_nxt [NUM_MOTORS];
  logic [DUTY_W-1:0]       o4_duty_r [NUM_MOTORS];
  logic [DUTY_W-1:0]       o5_duty_r [NUM_MOTORS];
  logic signed [SUM_W-1:0] a [NUM_MOTORS];
  logic signed [SUM_W-1:0] rs, ps, ys;
  logic signed [SD_W-1:0]  rd_nxt, pd_nxt, yd_nxt, o5_rd_r, o5_pd_r, o5_yd_r;
  logic [DUTY_W-1:0]       top01, top23, top_nxt, head_nxt, o5_head_r;
  out_word_t               out_nxt, out_data_r;

  function automatic logic signed [M_W-1:0] ext_m(dval_t x);
    return {{(M_W-D_W){x[D_W-1]}}, x};
  endfunction

  function automatic logic signed [FD_W-1:0] ext_c(logic signed [CORR_W-1:0] x);
    return {{(FD_W-CORR_W){x[CORR_W-1]}}, x};
  endfunction

  function automatic logic signed [FD_W-1:0] ext_d(logic signed [SD_W-1:0] x);
    return {{(FD_W-SD_W){x[SD_W-1]}}, x};
  endfunction

  function automatic logic over_one(logic signed [FD_W-1:0] x);
    return x > FD_W'(ONE_Q);
  endfunction

  // Scaled offsets replace the raw ones when the span was too wide.
  always_comb begin
    dval_t q_s;
    o1_nxt = in_side;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      q_s = {1'b0, in_div.quo[i]};
      if (in_div.scale) begin
        o1_nxt.d[i] = in_div.neg[i] ? -q_s : q_s;
      end else begin
        o1_nxt.d[i] = in_side.d[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      dsel[i] = o1_side_r.d[i];
    end
    hi01    = (dsel[0] > dsel[1]) ? dsel[0] : dsel[1];
    hi23    = (dsel[2] > dsel[3]) ? dsel[2] : dsel[3];
    lo01    = (dsel[0] < dsel[1]) ? dsel[0] : dsel[1];
    lo23    = (dsel[2] < dsel[3]) ? dsel[2] : dsel[3];
    max_nxt = (hi01 > hi23) ? hi01 : hi23;
    min_nxt = (lo01 < lo23) ? lo01 : lo23;
  end

  always_comb begin
    thr_s = $signed({{(M_W-LIM_W){1'b0}}, o2_side_r.thr});
    lim_s = $signed({{(M_W-LIM_W){1'b0}}, max_duty, {FRAC_BITS{1'b0}}});
    hi_s  = thr_s + ext_m(o2_max_r);
    lo_s  = thr_s + ext_m(o2_min_r);
    for (int i = 0; i < NUM_MOTORS; i++) begin
      m_nxt[i] = thr_s + ext_m(o2_side_r.d[i]);
    end
    priority if (hi_s > lim_s) begin
      shift_nxt = {lim_s[M_W-1], lim_s} - {hi_s[M_W-1], hi_s};
    end else if (lo_s[M_W-1]) begin
      shift_nxt = -{lo_s[M_W-1], lo_s};
    end else begin
      shift_nxt = '0;
    end
  end

  always_comb begin
    logic signed [V_W-1:0]      v;
    logic [V_W-FRAC_BITS-2:0]   whole;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      v     = {{2{o3_m_r[i][M_W-1]}}, o3_m_r[i]} + {o3_shift_r[M_W], o3_shift_r};
      whole = v[V_W-2:FRAC_BITS];
      if (v[V_W-1] || v == '0) begin
        duty_nxt[i] = '0;
      end else if (whole > {{(V_W-1-FRAC_BITS-DUTY_W){1'b0}}, max_duty}) begin
        duty_nxt[i] = max_duty;
      end else begin
        duty_nxt[i] = whole[DUTY_W-1:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      a[i] = $signed({{(SUM_W-DUTY_W){1'b0}}, o4_duty_r[i]});
    end
    rs       = (a[M_BR] + a[M_FR]) - (a[M_FL] + a[M_BL]);
    ps       = (a[M_FR] + a[M_FL]) - (a[M_BR] + a[M_BL]);
    ys       = (a[M_FR] + a[M_BL]) - (a[M_BR] + a[M_FL]);
    rd_nxt   = {rs, {(FRAC_BITS-2){1'b0}}};
    pd_nxt   = {ps, {(FRAC_BITS-2){1'b0}}};
    yd_nxt   = {ys, {(FRAC_BITS-2){1'b0}}};
    top01    = (o4_duty_r[0] > o4_duty_r[1]) ? o4_duty_r[0] : o4_duty_r[1];
    top23    = (o4_duty_r[2] > o4_duty_r[3]) ? o4_duty_r[2] : o4_duty_r[3];
    top_nxt  = (top01 > top23) ? top01 : top23;
    head_nxt = max_duty - top_nxt;
  end

  always_comb begin
    out_nxt.motor_back_right  = o5_duty_r[M_BR];
    out_nxt.motor_front_right = o5_duty_r[M_FR];
    out_nxt.motor_front_left  = o5_duty_r[M_FL];
    out_nxt.motor_back_left   = o5_duty_r[M_BL];
    out_nxt.roll_short_pos    = over_one(ext_c(o5_side_r.roll) - ext_d(o5_rd_r));
    out_nxt.roll_short_neg    = over_one(ext_d(o5_rd_r) - ext_c(o5_side_r.roll));
    out_nxt.pitch_short_pos   = over_one(ext_c(o5_side_r.pitch) - ext_d(o5_pd_r));
    out_nxt.pitch_short_neg   = over_one(ext_d(o5_pd_r) - ext_c(o5_side_r.pitch));
    out_nxt.yaw_short_pos     = over_one(ext_c(o5_side_r.yaw) - ext_d(o5_yd_r));
    out_nxt.yaw_short_neg     = over_one(ext_d(o5_yd_r) - ext_c(o5_side_r.yaw));
    out_nxt.any_saturated     = out_nxt.roll_short_pos | out_nxt.roll_short_neg |
                                out_nxt.pitch_short_pos | out_nxt.pitch_short_neg |
                                out_nxt.yaw_short_pos | out_nxt.yaw_short_neg;
    out_nxt.headroom          = o5_head_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o1_vld_r    <= 1'b0;
      o2_vld_r    <= 1'b0;
      o3_vld_r    <= 1'b0;
      o4_vld_r    <= 1'b0;
      o5_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      o1_vld_r    <= in_valid;
      o2_vld_r    <= o1_vld_r;
      o3_vld_r    <= o2_vld_r;
      o4_vld_r    <= o3_vld_r;
      o5_vld_r    <= o4_vld_r;
      out_valid_r <= o5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    o1_side_r  <= o1_nxt;
    o2_side_r  <= o1_side_r;
    o2_max_r   <= max_nxt;
    o2_min_r   <= min_nxt;
    o3_side_r  <= o2_side_r;
    o3_m_r     <= m_nxt;
    o3_shift_r <= shift_nxt;
    o4_side_r  <= o3_side_r;
    o4_duty_r  <= duty_nxt;
    o5_side_r  <= o4_side_r;
    o5_duty_r  <= o4_duty_r;
    o5_rd_r    <= rd_nxt;
    o5_pd_r    <= pd_nxt;
    o5_yd_r    <= yd_nxt;
    o5_head_r  <= head_nxt;
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/quad_x_mixer_desaturate_top.sv */
// Top level of the quad-X motor mixer with desaturation and saturation flags.
// An accepted start passes the mix stages, the divider and the output stages before the out_valid strobe of its word.
// Throughput: one word per cycle while busy is low; the 25-stage divider pipeline makes up most of the depth.
// The receiver cannot stall, so busy is low at all times except during reset and until the
// first clock edge that sees rst_n high. Reset clears all valid bits and sets max_duty to 1023.
`include "quad_x_mixer_desaturate_top_defines.svh"

module quad_x_mixer_desaturate_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  qxmd_pkg::in_word_t          in_data,
  input  logic                        cfg_we,
  input  logic [qxmd_pkg::DUTY_W-1:0] cfg_wdata,
  output logic                        out_valid,
  output qxmd_pkg::out_word_t         out_data
);
  import qxmd_pkg::*;

  logic              busy_r;
  logic [DUTY_W-1:0] max_duty_r;
  logic              in_fire;
  logic              mix_valid, div_valid;
  side_t             mix_side, div_side;
  div_word_t         mix_div, div_word;

  assign in_fire = start & ~busy_r;
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      max_duty_r <= MAX_DUTY_RST;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        max_duty_r <= cfg_wdata;
      end
    end
  end

  qxmd_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_fire),
    .in_data   (in_data),
    .max_duty  (max_duty_r),
    .out_valid (mix_valid),
    .out_side  (mix_side),
    .out_div   (mix_div)
  );

  qxmd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mix_valid),
    .in_side   (mix_side),
    .in_div    (mix_div),
    .out_valid (div_valid),
    .out_side  (div_side),
    .out_div   (div_word)
  );

  qxmd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_side   (div_side),
    .in_div    (div_word),
    .max_duty  (max_duty_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `QXMD_ASSERT(a_fixed_latency, clk, rst_n, start && !busy |-> ##PIPE_DEPTH out_valid)
  `QXMD_ASSERT_IMP(a_any_matches_flags, clk, rst_n, out_valid, out_data.any_saturated == (out_data.roll_short_pos || out_data.roll_short_neg || out_data.pitch_short_pos || out_data.pitch_short_neg || out_data.yaw_short_pos || out_data.yaw_short_neg))
  `QXMD_ASSERT_IMP(a_flags_exclusive, clk, rst_n, out_valid, !(out_data.roll_short_pos && out_data.roll_short_neg) && !(out_data.pitch_short_pos && out_data.pitch_short_neg) && !(out_data.yaw_short_pos && out_data.yaw_short_neg))

endmodule

/* sim/quad_x_mixer_desaturate_checker.sv */
`timescale 1ns / 100ps
// Checker of the quad-X mixer: predicts each result word and compares it field by field.
module quad_x_mixer_desaturate_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  qxmd_pkg::in_word_t          in_data,
  input  logic                        cfg_we,
  input  logic [qxmd_pkg::DUTY_W-1:0] cfg_wdata,
  input  logic                        out_valid,
  input  qxmd_pkg::out_word_t         out_data,
  output int                          errors,
  output int                          pending
);
  import qxmd_pkg::*;

  out_word_t         duty_queue[$];
  out_word_t         want_word;
  logic [DUTY_W-1:0] duty_cap = MAX_DUTY_RST;
  int                accepted_words = 0;
  int                checked_words = 0;
  int                error_count = 0;

  assign errors  = error_count;
  assign pending = accepted_words - checked_words;

  function automatic out_word_t mix_word(in_word_t w, logic [DUTY_W-1:0] cap_reg);
    longint    one, cap, lim, thr, r, p, y, span, shift, mx, mn, q;
    longint    rd, pd, yd, quarter, top;
    longint    m[NUM_MOTORS];
    longint    a[NUM_MOTORS];
    out_word_t o;
    one = longint'(ONE_Q);
    cap = longint'(cap_reg);
    lim = cap * one;
    thr = longint'(w.base_duty) * one;
    r = longint'($signed(w.roll_cmd));
    p = longint'($signed(w.pitch_cmd));
    y = longint'($signed(w.yaw_cmd));
    m[M_BR] = thr - p + r - y;
    m[M_FR] = thr + p + r + y;
    m[M_FL] = thr + p - r - y;
    m[M_BL] = thr - p - r + y;
    mx = m[0];
    mn = m[0];
    for (int i = 1; i < NUM_MOTORS; i++) begin
      if (m[i] > mx) mx = m[i];
      if (m[i] < mn) mn = m[i];
    end
    span = mx - mn;
    if (span > lim && span > 0) begin
      for (int i = 0; i < NUM_MOTORS; i++) m[i] = thr + ((m[i] - thr) * lim) / span;
      mx = m[0];
      mn = m[0];
      for (int i = 1; i < NUM_MOTORS; i++) begin
        if (m[i] > mx) mx = m[i];
        if (m[i] < mn) mn = m[i];
      end
    end
    shift = 0;
    if (mx > lim) shift = lim - mx;
    else if (mn < 0) shift = -mn;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      q = m[i] + shift;
      if (q <= 0) a[i] = 0;
      else begin
        a[i] = q >>> FRAC_BITS;
        if (a[i] > cap) a[i] = cap;
      end
    end
    quarter = longint'(1) <<< (FRAC_BITS - 2);
    rd = ((a[M_BR] + a[M_FR]) - (a[M_FL] + a[M_BL])) * quarter;
    pd = ((a[M_FR] + a[M_FL]) - (a[M_BR] + a[M_BL])) * quarter;
    yd = ((a[M_FR] + a[M_BL]) - (a[M_BR] + a[M_FL])) * quarter;
    o.motor_back_right  = DUTY_W'(a[M_BR]);
    o.motor_front_right = DUTY_W'(a[M_FR]);
    o.motor_front_left  = DUTY_W'(a[M_FL]);
    o.motor_back_left   = DUTY_W'(a[M_BL]);
    o.roll_short_pos    = (r - rd) > one;
    o.roll_short_neg    = (rd - r) > one;
    o.pitch_short_pos   = (p - pd) > one;
    o.pitch_short_neg   = (pd - p) > one;
    o.yaw_short_pos     = (y - yd) > one;
    o.yaw_short_neg     = (yd - y) > one;
    o.any_saturated     = o.roll_short_pos | o.roll_short_neg | o.pitch_short_pos |
                          o.pitch_short_neg | o.yaw_short_pos | o.yaw_short_neg;
    top = a[0];
    for (int i = 1; i < NUM_MOTORS; i++) if (a[i] > top) top = a[i];
    o.headroom = DUTY_W'(cap - top);
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("%0t: word %0d, %s: got %0d, expected %0d", $time, checked_words, what, got,
             want);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      duty_queue.delete();
      duty_cap = MAX_DUTY_RST;
      accepted_words <= 0;
      checked_words <= 0;
    end else begin
      if (out_valid) begin
        if (duty_queue.size() == 0) begin
          report_mismatch("out_valid with no word pending", 1, 0);
        end else begin
          want_word = duty_queue.pop_front();
          checked_words <= checked_words + 1;
          if (out_data.motor_back_right !== want_word.motor_back_right)
            report_mismatch("motor_back_right", out_data.motor_back_right,
                            want_word.motor_back_right);
          if (out_data.motor_front_right !== want_word.motor_front_right)
            report_mismatch("motor_front_right", out_data.motor_front_right,
                            want_word.motor_front_right);
          if (out_data.motor_front_left !== want_word.motor_front_left)
            report_mismatch("motor_front_left", out_data.motor_front_left,
                            want_word.motor_front_left);
          if (out_data.motor_back_left !== want_word.motor_back_left)
            report_mismatch("motor_back_left", out_data.motor_back_left,
                            want_word.motor_back_left);
          if (out_data.roll_short_pos !== want_word.roll_short_pos)
            report_mismatch("roll_short_pos", out_data.roll_short_pos, want_word.roll_short_pos);
          if (out_data.roll_short_neg !== want_word.roll_short_neg)
            report_mismatch("roll_short_neg", out_data.roll_short_neg, want_word.roll_short_neg);
          if (out_data.pitch_short_pos !== want_word.pitch_short_pos)
            report_mismatch("pitch_short_pos", out_data.pitch_short_pos,
                            want_word.pitch_short_pos);
          if (out_data.pitch_short_neg !== want_word.pitch_short_neg)
            report_mismatch("pitch_short_neg", out_data.pitch_short_neg,
                            want_word.pitch_short_neg);
          if (out_data.yaw_short_pos !== want_word.yaw_short_pos)
            report_mismatch("yaw_short_pos", out_data.yaw_short_pos, want_word.yaw_short_pos);
          if (out_data.yaw_short_neg !== want_word.yaw_short_neg)
            report_mismatch("yaw_short_neg", out_data.yaw_short_neg, want_word.yaw_short_neg);
          if (out_data.any_saturated !== want_word.any_saturated)
            report_mismatch("any_saturated", out_data.any_saturated, want_word.any_saturated);
          if (out_data.headroom !== want_word.headroom)
            report_mismatch("headroom", out_data.headroom, want_word.headroom);
        end
      end
      if (start && !busy) begin
        duty_queue.push_back(mix_word(in_data, duty_cap));
        accepted_words <= accepted_words + 1;
      end
      if (cfg_we) duty_cap = cfg_wdata;
    end
  end

endmodule

/* sim/quad_x_mixer_desaturate_top_test.sv */
`timescale 1ns / 100ps
// Testbench top of the quad-X mixer: reset, duty-limit phases, stimulus and verdict.
module quad_x_mixer_desaturate_top_test;
  import qxmd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 7;
  localparam int PHASE_WORDS = 150;
  localparam logic signed [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
  localparam logic signed [CORR_W-1:0] CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  in_word_t          in_data = '0;
  logic              cfg_we = 1'b0;
  logic [DUTY_W-1:0] cfg_wdata = '0;
  logic              busy;
  logic              out_valid;
  out_word_t         out_data;
  int                errors;
  int                pending;
  int                cycles = 0;
  int                idle_pct = 0;
  int                phase_cap;
  int                cap_list[PHASES] = '{1, 65535, 1023, 0, 2, 255, 0};
  int                idle_list[PHASES] = '{81, 0, 30, 81, 30, 0, 81};

  quad_x_mixer_desaturate_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  quad_x_mixer_desaturate_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("quad_x_mixer_desaturate_top_test: FAIL");
      $finish;
    end
  end

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [CORR_W-1:0] rand_corr(int unsigned k);
    logic signed [CORR_W-1:0] v;
    v = CORR_W'($urandom);
    return v >>> (CORR_W - 1 - k);
  endfunction

  function automatic logic signed [CORR_W-1:0] pick_corr();
    case ($urandom_range(3))
      0: return CORR_MAX;
      1: return CORR_MIN;
      2: return '0;
      default: return rand_corr(CORR_W - 1);
    endcase
  endfunction

  function automatic in_word_t rand_word(int cap);
    in_word_t    w;
    int unsigned k;
    k = $urandom_range(CORR_W - 1, 2);
    w.base_duty = DUTY_W'($urandom_range(cap));
    w.roll_cmd  = rand_corr(k);
    w.pitch_cmd = rand_corr(k);
    w.yaw_cmd   = rand_corr(k);
    case ($urandom_range(9))
      0: begin
        w.base_duty = DUTY_W'($urandom);
        w.roll_cmd  = rand_corr(CORR_W - 1);
        w.pitch_cmd = rand_corr(CORR_W - 1);
        w.yaw_cmd   = rand_corr(CORR_W - 1);
      end
      1: w.base_duty = DUTY_W'($urandom_range(65535));
      2: w.base_duty = DUTY_W'($urandom_range(3));
      3: w.base_duty = DUTY_W'($urandom_range(cap, (cap > 3) ? cap - 3 : 0));
      4: begin
        w.roll_cmd  = pick_corr();
        w.pitch_cmd = pick_corr();
        w.yaw_cmd   = pick_corr();
      end
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_word({16'd0, 24'sd0, 24'sd0, 24'sd0});
    send_word({16'd65535, 24'sd0, 24'sd0, 24'sd0});
    send_word({16'd1023, 24'sd0, 24'sd0, 24'sd0});
    send_word({16'd512, 24'sd256, 24'sd0, 24'sd0});
    send_word({16'd512, 24'sd257, 24'sd0, 24'sd0});
    send_word({16'd512, 24'sd0, -24'sd300, 24'sd0});
    send_word({16'd512, 24'sd0, 24'sd0, 24'sd5000});
    send_word({16'd512, CORR_MAX, 24'sd0, 24'sd0});
    send_word({16'd512, CORR_MIN, 24'sd0, 24'sd0});
    send_word({16'd512, 24'sd0, CORR_MAX, 24'sd0});
    send_word({16'd512, 24'sd0, CORR_MIN, 24'sd0});
    send_word({16'd512, 24'sd0, 24'sd0, CORR_MAX});
    send_word({16'd512, 24'sd0, 24'sd0, CORR_MIN});
    send_word({16'd0, CORR_MAX, CORR_MAX, CORR_MAX});
    send_word({16'd65535, CORR_MIN, CORR_MIN, CORR_MIN});
    send_word({16'd1000, 24'sd20000, 24'sd10000, 24'sd0});
    send_word({16'd10, -24'sd4000, 24'sd1500, -24'sd700});
    send_word({16'd1020, 24'sd2560, 24'sd0, 24'sd0});
    send_word({16'd0, CORR_MIN, CORR_MAX, CORR_MIN});
    send_word({16'd300, -24'sd513, 24'sd511, -24'sd1});

    for (int ph = 0; ph < PHASES; ph++) begin
      start <= 1'b0;
      while (pending != 0) @(posedge clk);
      repeat (PIPE_DEPTH) @(posedge clk);
      phase_cap = (cap_list[ph] != 0) ? cap_list[ph] : $urandom_range(65535, 1);
      cfg_we <= 1'b1;
      cfg_wdata <= DUTY_W'(phase_cap);
      @(posedge clk);
      cfg_we <= 1'b0;
      idle_pct = idle_list[ph];
      for (int i = 0; i < PHASE_WORDS; i++) send_word(rand_word(phase_cap));
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (errors == 0) begin
      $display("quad_x_mixer_desaturate_top_test: PASS");
    end else begin
      $display("quad_x_mixer_desaturate_top_test: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/qxmd_pkg.sv
sv/qxmd_mix.sv
sv/qxmd_div.sv
sv/qxmd_out.sv
sv/quad_x_mixer_desaturate_top.sv
sim/quad_x_mixer_desaturate_checker.sv
sim/quad_x_mixer_desaturate_top_test.sv
